FILE: rtl/piecewise_poly_activation_lanes_core_macros.svh
// Assertion macros shared by the checker of the piecewise polynomial activation core.
`ifndef PIECEWISE_POLY_ACTIVATION_LANES_CORE_MACROS_SVH
`define PIECEWISE_POLY_ACTIVATION_LANES_CORE_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define PPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define PPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication that is also checked during reset.
`define PPA_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ppa_pkg.sv
// Shared constants and types of the piecewise polynomial activation core.
`default_nettype none

package ppa_pkg;

    localparam int DEF_LANES      = 4;
    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int WORD_W     = 64;
    localparam int COUNT_W    = 3;
    localparam int THRESH_W   = 15;
    localparam int DEGREES_W  = 6;
    localparam int DEG_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int NUM_REGIONS  = 3;
    localparam int NUM_COEFFS   = 4;
    localparam int HORNER_STEPS = NUM_COEFFS - 1;
    // One select stage, then a multiply stage and an add stage per Horner step.
    localparam int PIPE_STAGES  = 1 + 2 * HORNER_STEPS;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREES       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_COEFFS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_COEFFS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_COEFFS  = 3'd4;

    typedef enum logic [1:0] {
        REGION_LOWER  = 2'd0,
        REGION_MIDDLE = 2'd1,
        REGION_UPPER  = 2'd2
    } region_t;

endpackage

`default_nettype wire

FILE: rtl/ppa_lane.sv
// One lane of the activation pipeline: region select, then three Horner steps.
`default_nettype none

module ppa_lane #(
    parameter int DATA_WIDTH = ppa_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = ppa_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                clk,
    input  wire logic [ppa_pkg::PIPE_STAGES-1:0]     stage_load,
    input  wire logic signed [DATA_WIDTH-1:0]        x,
    input  wire logic                                lane_on,
    input  wire logic [ppa_pkg::THRESH_W-1:0]        threshold,
    input  wire logic [ppa_pkg::DEG_W-1:0]           degree [ppa_pkg::NUM_REGIONS],
    input  wire logic signed [DATA_WIDTH-1:0]
                                 coef [ppa_pkg::NUM_REGIONS][ppa_pkg::NUM_COEFFS],
    output logic signed [DATA_WIDTH-1:0]             y
);

    localparam int STEPS = ppa_pkg::HORNER_STEPS;
    localparam int CMP_W = ((DATA_WIDTH > ppa_pkg::THRESH_W + 1) ?
                            DATA_WIDTH : ppa_pkg::THRESH_W + 1) + 1;

    // Region select on the incoming sample.
    logic signed [CMP_W-1:0]        x_cmp;
    logic signed [CMP_W-1:0]        lim_pos;
    logic signed [CMP_W-1:0]        lim_neg;
    ppa_pkg::region_t               region;
    logic [ppa_pkg::DEG_W-1:0]      deg_sel;
    logic signed [DATA_WIDTH-1:0]   acc_sel;

    assign x_cmp   = CMP_W'(x);
    assign lim_pos = CMP_W'(threshold);
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (x_cmp < lim_neg)
        begin
            region = ppa_pkg::REGION_LOWER;
        end
        else if (x_cmp > lim_pos)
        begin
            region = ppa_pkg::REGION_UPPER;
        end
        else
        begin
            region = ppa_pkg::REGION_MIDDLE;
        end
    end

    // An unused lane runs with degree zero and a zero accumulator, so it yields zero.
    assign deg_sel = lane_on ? degree[region] : '0;
    assign acc_sel = lane_on ? coef[region][deg_sel] : '0;

    // Values at the input of each multiply stage (index 0 is the select stage).
    logic signed [DATA_WIDTH-1:0]   acc_reg [STEPS+1];
    logic signed [DATA_WIDTH-1:0]   xa_reg  [STEPS+1];
    ppa_pkg::region_t               ra_reg  [STEPS+1];
    logic [ppa_pkg::DEG_W-1:0]      da_reg  [STEPS+1];

    // Values held by each multiply stage.
    logic signed [2*DATA_WIDTH-1:0] prod_reg [STEPS];
    logic signed [DATA_WIDTH-1:0]   accm_reg [STEPS];
    logic signed [DATA_WIDTH-1:0]   xm_reg   [STEPS];
    ppa_pkg::region_t               rm_reg   [STEPS];
    logic [ppa_pkg::DEG_W-1:0]      dm_reg   [STEPS];

    logic signed [DATA_WIDTH-1:0]   acc_next [STEPS];

    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        // Step s adds coefficient a_k; it applies only when k is below the degree.
        localparam logic [ppa_pkg::DEG_W-1:0] K = ppa_pkg::DEG_W'(STEPS - 1 - s);
        logic signed [2*DATA_WIDTH-1:0] prod_sh;
        logic signed [DATA_WIDTH-1:0]   sum;

        assign prod_sh     = prod_reg[s] >>> FRAC_BITS;
        assign sum         = DATA_WIDTH'(prod_sh) + coef[rm_reg[s]][K];
        assign acc_next[s] = (dm_reg[s] > K) ? sum : accm_reg[s];
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            acc_reg[0] <= acc_sel;
            xa_reg[0]  <= x;
            ra_reg[0]  <= region;
            da_reg[0]  <= deg_sel;
        end
        for (int s = 0; s < STEPS; s++)
        begin
            if (stage_load[2*s+1])
            begin
                prod_reg[s] <= acc_reg[s] * xa_reg[s];
                accm_reg[s] <= acc_reg[s];
                xm_reg[s]   <= xa_reg[s];
                rm_reg[s]   <= ra_reg[s];
                dm_reg[s]   <= da_reg[s];
            end
            if (stage_load[2*s+2])
            begin
                acc_reg[s+1] <= acc_next[s];
                xa_reg[s+1]  <= xm_reg[s];
                ra_reg[s+1]  <= rm_reg[s];
                da_reg[s+1]  <= dm_reg[s];
            end
        end
    end

    assign y = acc_reg[STEPS];

endmodule

`default_nettype wire

FILE: rtl/piecewise_poly_activation_lanes_core.sv
// Top level of the lane-parallel piecewise cubic activation core.
//
// Usage:
//   Input channel: in_valid / in_stall carry one beat of sample_word (LANES packed
//   signed fixed-point samples, lane 0 lowest) and valid_lanes (the number of
//   leading lanes that hold real samples). Lanes at or above valid_lanes give zero.
//   Output channel: out_valid / out_stall carry one beat of result_word per input
//   beat, in order. A beat moves at a clock edge with valid high and stall low.
//   Configuration: cfg_wen writes cfg_data to register cfg_index (threshold,
//   degrees, lower, middle and upper coefficients). Write only while idle.
//   The pipeline has 7 register stages: one stage picks the region and the top
//   coefficient, then each of the three Horner steps takes one multiply stage and
//   one shift-and-add stage. An accepted beat moves through the stages in order,
//   and out_valid is the valid bit of the last one. Throughput is one beat per cycle
//   while out_stall is low; the pipeline is bounded by the multiply stage of each step.
//   When the receiver stalls, the result register holds its beat, and upstream
//   stages keep filling any bubbles; in_stall rises only when every stage is full.
//   Reset clears all valid bits and all configuration registers to zero.
`default_nettype none

module piecewise_poly_activation_lanes_core #(
    parameter int LANES      = ppa_pkg::DEF_LANES,
    parameter int DATA_WIDTH = ppa_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = ppa_pkg::DEF_FRAC_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_wen,
    input  wire logic [ppa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ppa_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ppa_pkg::WORD_W-1:0]        sample_word,
    input  wire logic [ppa_pkg::COUNT_W-1:0]       valid_lanes,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [ppa_pkg::WORD_W-1:0]             result_word
);

    localparam int STAGES    = ppa_pkg::PIPE_STAGES;
    localparam int LANE_BITS = LANES * DATA_WIDTH;
    // Lanes and coefficient fields past the 64-bit word read as zero.
    localparam int SAMPLE_PAD_W = (LANE_BITS > ppa_pkg::WORD_W) ?
                                  LANE_BITS : ppa_pkg::WORD_W;
    localparam int COEF_BITS    = ppa_pkg::NUM_COEFFS * DATA_WIDTH;
    localparam int COEF_PAD_W   = (COEF_BITS > ppa_pkg::CFG_DATA_W) ?
                                  COEF_BITS : ppa_pkg::CFG_DATA_W;

    // Configuration registers.
    logic [ppa_pkg::THRESH_W-1:0]   threshold_reg;
    logic [ppa_pkg::DEGREES_W-1:0]  degrees_reg;
    logic [ppa_pkg::CFG_DATA_W-1:0] coeffs_reg [ppa_pkg::NUM_REGIONS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            degrees_reg   <= '0;
            for (int r = 0; r < ppa_pkg::NUM_REGIONS; r++)
            begin
                coeffs_reg[r] <= '0;
            end
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                ppa_pkg::CFG_THRESHOLD:
                    threshold_reg <= cfg_data[ppa_pkg::THRESH_W-1:0];
                ppa_pkg::CFG_DEGREES:
                    degrees_reg <= cfg_data[ppa_pkg::DEGREES_W-1:0];
                ppa_pkg::CFG_LOWER_COEFFS:
                    coeffs_reg[ppa_pkg::REGION_LOWER] <= cfg_data;
                ppa_pkg::CFG_MIDDLE_COEFFS:
                    coeffs_reg[ppa_pkg::REGION_MIDDLE] <= cfg_data;
                ppa_pkg::CFG_UPPER_COEFFS:
                    coeffs_reg[ppa_pkg::REGION_UPPER] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Unpack the per-region degree and coefficient fields. Region order matches
    // the bit order of the degree register: lower, middle, upper.
    logic [ppa_pkg::DEG_W-1:0]    degree [ppa_pkg::NUM_REGIONS];
    logic signed [DATA_WIDTH-1:0] coef   [ppa_pkg::NUM_REGIONS][ppa_pkg::NUM_COEFFS];

    for (genvar r = 0; r < ppa_pkg::NUM_REGIONS; r++)
    begin : g_region
        logic [COEF_PAD_W-1:0] coef_pad;

        assign degree[r] = degrees_reg[r*ppa_pkg::DEG_W +: ppa_pkg::DEG_W];
        assign coef_pad  = COEF_PAD_W'(coeffs_reg[r]);
        for (genvar k = 0; k < ppa_pkg::NUM_COEFFS; k++)
        begin : g_coef
            assign coef[r][k] = coef_pad[k*DATA_WIDTH +: DATA_WIDTH];
        end
    end

    // Pipeline control. A stage takes a new beat when it is empty or when its
    // own beat moves on in the same cycle, so bubbles are squeezed out under stall.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] stage_ready;
    logic [STAGES-1:0] stage_load;

    assign stage_ready[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
    for (genvar i = 0; i < STAGES - 1; i++)
    begin : g_ready
        assign stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
    end

    assign stage_load[0] = stage_ready[0] && in_valid;
    for (genvar i = 1; i < STAGES; i++)
    begin : g_load
        assign stage_load[i] = stage_ready[i] && valid_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign in_stall  = !stage_ready[0];
    assign out_valid = valid_reg[STAGES-1];

    // Lane datapaths.
    logic [SAMPLE_PAD_W-1:0] sample_pad;
    logic [LANE_BITS-1:0]    result_full;

    assign sample_pad = SAMPLE_PAD_W'(sample_word);

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [DATA_WIDTH-1:0] lane_x;
        logic signed [DATA_WIDTH-1:0] lane_y;
        logic                         lane_on;

        assign lane_x  = sample_pad[l*DATA_WIDTH +: DATA_WIDTH];
        // A count above LANES leaves every lane in use.
        assign lane_on = (32'(valid_lanes) > l);

        ppa_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .clk        (clk),
            .stage_load (stage_load),
            .x          (lane_x),
            .lane_on    (lane_on),
            .threshold  (threshold_reg),
            .degree     (degree),
            .coef       (coef),
            .y          (lane_y)
        );

        assign result_full[l*DATA_WIDTH +: DATA_WIDTH] = lane_y;
    end

    // Lanes past bit 63 are dropped; a short lane word is padded with zeros.
    assign result_word = ppa_pkg::WORD_W'(result_full);

endmodule

`default_nettype wire

FILE: rtl/ppa_checker.sv
// Port-level checker for the piecewise polynomial activation core, bound to the top level.
`default_nettype none

`include "piecewise_poly_activation_lanes_core_macros.svh"

module ppa_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [ppa_pkg::WORD_W-1:0] result_word
);

    // No result may be presented while reset is held; before the first edge
    // clears them the valid bits are still unknown, which is not a result.
    `PPA_ASSERT_ALWAYS(a_reset_quiet, !rst_n, out_valid !== 1'b1, "out_valid high in reset")

    // With the result register empty, every stage can take a beat.
    `PPA_ASSERT_NOW(a_empty_ready, !out_valid, !in_stall, "input stalled with output empty")

    // A result leaving the block frees the whole pipeline in the same cycle.
    `PPA_ASSERT_NOW(a_drain_ready, out_valid && !out_stall, !in_stall, "stall while draining")

    // A stalled result beat stays and holds its value.
    `PPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(result_word), "stalled result changed")

endmodule

bind piecewise_poly_activation_lanes_core ppa_checker u_ppa_checker (.*);

`default_nettype wire

FILE: verif/tb_piecewise_poly_activation_lanes_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the lane-parallel piecewise cubic activation core.
module tb_piecewise_poly_activation_lanes_core;

    // Lane geometry follows the default build of the core.
    localparam int LANE_W  = ppa_pkg::DEF_DATA_WIDTH;
    localparam int SHIFT   = ppa_pkg::DEF_FRAC_BITS;
    localparam int LANES_N = ppa_pkg::DEF_LANES;

    // Port and register widths of the core.
    localparam int CFG_IDX_W   = ppa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = ppa_pkg::CFG_DATA_W;
    localparam int WORD_W      = ppa_pkg::WORD_W;
    localparam int COUNT_W     = ppa_pkg::COUNT_W;
    localparam int THRESH_W    = ppa_pkg::THRESH_W;
    localparam int DEGREES_W   = ppa_pkg::DEGREES_W;
    localparam int DEG_W       = ppa_pkg::DEG_W;
    localparam int NUM_REGIONS = ppa_pkg::NUM_REGIONS;
    localparam int NUM_COEFFS  = ppa_pkg::NUM_COEFFS;

    // Percentage of cycles in which each side holds back.
    localparam int IDLE_PCT = 27;

    // The random part runs in phases, each with its own register setting.
    // The phase named below runs with no idling on either side.
    localparam int PHASES          = 8;
    localparam int BEATS_PER_PHASE = 232;
    localparam int QUIET_PHASE     = 4;

    // Cycles to wait once nothing is pending, and cycles with no accepted beat on
    // either channel before the run is declared hung.
    localparam int DRAIN_CYCLES = 2 * ppa_pkg::PIPE_STAGES + 4;
    localparam int HANG_LIMIT   = 2000;

    // Index past the last register; a write to it must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    // Every input starts at a known value before the first clock edge.
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wen     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [WORD_W-1:0]     sample_word = '0;
    logic [COUNT_W-1:0]    valid_lanes = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [WORD_W-1:0]     result_word;

    piecewise_poly_activation_lanes_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_word (sample_word),
        .valid_lanes (valid_lanes),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_word (result_word)
    );

    always #5 clk = ~clk;

    // Shadow copy of the register file, kept in step with every write we make.
    // The coefficient banks are indexed by region, the same order the degree
    // field uses: lower, middle, upper.
    logic [THRESH_W-1:0]  bound_level = '0;
    logic [DEGREES_W-1:0] degree_bits = '0;
    logic [WORD_W-1:0]    coeff_bank [NUM_REGIONS] = '{default: '0};

    // Result words owed by the core, oldest first.
    logic [WORD_W-1:0] pending_results [$];
    logic [WORD_W-1:0] owed_word;

    int  mismatches   = 0;
    int  quiet_cycles = 0;
    bit  no_idle      = 1'b0;

    // Directed stimulus. Each row is either a register write or one input beat.
    // A beat whose result is plain to see carries it in the golden column;
    // every other beat is checked against the lane predictor.
    typedef enum logic {
        ROW_WRITE,
        ROW_BEAT
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [WORD_W-1:0]    value;
        logic [COUNT_W-1:0]   lanes;
        logic                 typed;
        logic [WORD_W-1:0]    golden;
    } directed_row_t;

    localparam int NUM_ROWS = 25;

    directed_row_t directed_rows [NUM_ROWS] = '{
        // Out of reset every region is degree 0 with zero coefficients.
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'h8000_7FFF_0001_FFFF, 3'd4, 1'b1, 64'h0},
        // All-ones writes: the threshold and degree registers keep only their width.
        '{ROW_WRITE, ppa_pkg::CFG_DEGREES,   64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b0, 64'h0},
        '{ROW_WRITE, ppa_pkg::CFG_THRESHOLD, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b0, 64'h0},
        '{ROW_WRITE, ppa_pkg::CFG_LOWER_COEFFS, 64'h8000_8000_8000_8000, 3'd0, 1'b0, 64'h0},
        '{ROW_WRITE, ppa_pkg::CFG_MIDDLE_COEFFS, 64'h7FFF_7FFF_7FFF_7FFF, 3'd0, 1'b0, 64'h0},
        '{ROW_WRITE, ppa_pkg::CFG_UPPER_COEFFS, 64'h0100_0000_0000_0000, 3'd0, 1'b0, 64'h0},
        // Widest bound: only the most negative sample falls in the lower region,
        // and cubic evaluation with full-scale coefficients wraps repeatedly.
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'h8000_7FFF_0001_FFFF, 3'd4, 1'b0, 64'h0},
        // No valid lanes at all.
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'h8000_7FFF_0001_FFFF, 3'd0, 1'b1, 64'h0},
        // A lane count above the lane total makes every lane valid.
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'h8001_8000_7FFE_0000, 3'd7, 1'b0, 64'h0},
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'h1234_8000_4321_7FFF, 3'd3, 1'b0, 64'h0},
        // Zero bound: zero stays in the middle, plus and minus one leave it.
        '{ROW_WRITE, ppa_pkg::CFG_THRESHOLD, 64'h0000_0000_0000_0000, 3'd0, 1'b0, 64'h0},
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'h0000_0001_FFFF_0000, 3'd4, 1'b0, 64'h0},
        // Degree 0 everywhere: each lane returns its region's constant term.
        '{ROW_WRITE, ppa_pkg::CFG_DEGREES,   64'h0000_0000_0000_0000, 3'd0, 1'b0, 64'h0},
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'h0001_FFFF_0000_7FFF, 3'd4, 1'b1,
          64'h0000_8000_7FFF_0000},
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'h0001_FFFF_0000_7FFF, 3'd2, 1'b1,
          64'h0000_0000_7FFF_0000},
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'h0001_FFFF_0000_7FFF, 3'd5, 1'b1,
          64'h0000_8000_7FFF_0000},
        // Mixed degrees (lower cubic, middle quadratic, upper linear) around 1.0.
        '{ROW_WRITE, ppa_pkg::CFG_DEGREES,   64'h0000_0000_0000_001B, 3'd0, 1'b0, 64'h0},
        '{ROW_WRITE, ppa_pkg::CFG_THRESHOLD, 64'h0000_0000_0000_0100, 3'd0, 1'b0, 64'h0},
        '{ROW_WRITE, ppa_pkg::CFG_LOWER_COEFFS, 64'h0040_FF80_0100_FFC0, 3'd0, 1'b0, 64'h0},
        '{ROW_WRITE, ppa_pkg::CFG_MIDDLE_COEFFS, 64'h0000_0080_0100_0000, 3'd0, 1'b0, 64'h0},
        '{ROW_WRITE, ppa_pkg::CFG_UPPER_COEFFS, 64'h0000_0000_0100_0100, 3'd0, 1'b0, 64'h0},
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'hFEFF_FF00_0101_0100, 3'd4, 1'b0, 64'h0},
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'h8000_7FFF_FFFF_0000, 3'd4, 1'b0, 64'h0},
        // A write past the last register must not disturb any setting.
        '{ROW_WRITE, CFG_UNMAPPED,           64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b0, 64'h0},
        '{ROW_BEAT,  ppa_pkg::CFG_THRESHOLD, 64'hFEFF_FF00_0101_0100, 3'd6, 1'b0, 64'h0}
    };

    // Lane predictor. Each valid lane picks its region against the bound, then
    // runs Horner's rule from the top coefficient of that region's degree.
    // The product is exact; keeping bits [LANE_W+SHIFT-1:SHIFT] is the same as
    // a floor shift followed by a wrap to lane width. Sums wrap as well.
    function automatic logic [WORD_W-1:0] activation_word(
        input logic [WORD_W-1:0]  samples,
        input logic [COUNT_W-1:0] count
    );
        logic [WORD_W-1:0]          packed_out;
        logic [WORD_W-1:0]          coeffs;
        logic signed [LANE_W-1:0]   x;
        logic signed [LANE_W-1:0]   acc;
        logic signed [2*LANE_W-1:0] prod;
        ppa_pkg::region_t           region;
        int                         degree;

        packed_out = '0;
        for (int lane = 0; lane < LANES_N; lane++)
        begin
            if (lane < int'(count))
            begin
                x = samples[lane*LANE_W +: LANE_W];
                if (int'(x) < -int'(bound_level))
                    region = ppa_pkg::REGION_LOWER;
                else if (int'(x) > int'(bound_level))
                    region = ppa_pkg::REGION_UPPER;
                else
                    region = ppa_pkg::REGION_MIDDLE;
                degree = int'(degree_bits[int'(region)*DEG_W +: DEG_W]);
                coeffs = coeff_bank[int'(region)];
                acc = coeffs[degree*LANE_W +: LANE_W];
                for (int k = degree - 1; k >= 0; k--)
                begin
                    prod = acc * x;
                    acc = prod[LANE_W+SHIFT-1:SHIFT] + coeffs[k*LANE_W +: LANE_W];
                end
                packed_out[lane*LANE_W +: LANE_W] = acc;
            end
        end
        return packed_out;
    endfunction

    // One sample: full-range noise, values hugging the region bounds, the
    // extremes of the format, or small values where the polynomials stay sane.
    function automatic logic [LANE_W-1:0] random_sample();
        logic [LANE_W-1:0] v;
        int                pick;
        int                near;

        pick = $urandom_range(99);
        if (pick < 40)
            v = LANE_W'($urandom());
        else if (pick < 70)
        begin
            near = int'(bound_level) + int'($urandom_range(2)) - 1;
            if ($urandom_range(1) == 1)
                near = -near;
            v = near[LANE_W-1:0];
        end
        else if (pick < 80)
        begin
            case ($urandom_range(4))
                0: v = 16'h8000;
                1: v = 16'h7FFF;
                2: v = 16'h0000;
                3: v = 16'hFFFF;
                default: v = 16'h0001;
            endcase
        end
        else
        begin
            near = int'($urandom_range(16'h600)) - 16'h300;
            v = near[LANE_W-1:0];
        end
        return v;
    endfunction

    // One coefficient bank: each term is small, full-range or full-scale.
    function automatic logic [WORD_W-1:0] random_coeffs();
        logic [WORD_W-1:0] bank;
        int                term;

        for (int k = 0; k < NUM_COEFFS; k++)
        begin
            case ($urandom_range(3))
                0: bank[k*LANE_W +: LANE_W] = LANE_W'($urandom());
                1, 2:
                begin
                    term = int'($urandom_range(1023)) - 512;
                    bank[k*LANE_W +: LANE_W] = term[LANE_W-1:0];
                end
                default: bank[k*LANE_W +: LANE_W] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            endcase
        end
        return bank;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Register write. The core is only reconfigured with nothing in flight:
    // every input beat here owes exactly one result beat, so an empty pending list
    // means the pipeline is drained. Called and left at a falling edge.
    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            ppa_pkg::CFG_THRESHOLD:     bound_level = data[THRESH_W-1:0];
            ppa_pkg::CFG_DEGREES:       degree_bits = data[DEGREES_W-1:0];
            ppa_pkg::CFG_LOWER_COEFFS:  coeff_bank[ppa_pkg::REGION_LOWER] = data;
            ppa_pkg::CFG_MIDDLE_COEFFS: coeff_bank[ppa_pkg::REGION_MIDDLE] = data;
            ppa_pkg::CFG_UPPER_COEFFS:  coeff_bank[ppa_pkg::REGION_UPPER] = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Input beat. Called and left at a falling edge. A random number of idle
    // cycles may come first; valid is only lowered in an idle cycle, so a
    // back-to-back beat keeps valid high with no second assignment in the step.
    // The beat is accepted at the first rising edge that sees stall low.
    task automatic push_beat(
        input logic [WORD_W-1:0]  samples,
        input logic [COUNT_W-1:0] count,
        input logic               typed,
        input logic [WORD_W-1:0]  golden
    );
        if (!no_idle)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid    <= 1'b1;
        sample_word <= samples;
        valid_lanes <= count;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(typed ? golden : activation_word(samples, count));
        @(negedge clk);
    endtask

    // The receiver stalls at random, except during the quiet phase.
    always @(negedge clk)
    begin
        out_stall <= (rst_n === 1'b1) && !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // Result checker: every accepted result beat is matched against the oldest
    // word still owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result beat %h with no input beat behind it",
                                          result_word));
            else
            begin
                owed_word = pending_results.pop_front();
                if (result_word !== owed_word)
                    report_mismatch($sformatf("result_word %h, predicted %h",
                                              result_word, owed_word));
            end
        end
    end

    // Hang detector: too many cycles in a row with no beat accepted on either
    // channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("piecewise_poly_activation_lanes_core verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [WORD_W-1:0]     samples;
        logic [COUNT_W-1:0]    count;
        logic [CFG_DATA_W-1:0] setting;
        logic [THRESH_W-1:0]   bound;
        logic [DEGREES_W-1:0]  degrees;

        // Reset is held, then released at a falling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_WRITE)
                write_register(directed_rows[r].reg_idx, directed_rows[r].value);
            else
                push_beat(directed_rows[r].value, directed_rows[r].lanes,
                          directed_rows[r].typed, directed_rows[r].golden);
        end

        // Random phases. The first two pin the extremes of the settings: zero
        // bound with cubic everywhere, then the widest bound with full-scale
        // coefficients. The third uses constant terms only; the rest are random.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    bound   = '0;
                    degrees = '1;
                end
                1:
                begin
                    bound   = '1;
                    degrees = '1;
                end
                2:
                begin
                    bound   = THRESH_W'($urandom_range(16'h7FFF));
                    degrees = '0;
                end
                default:
                begin
                    case ($urandom_range(3))
                        0: bound = '0;
                        1: bound = '1;
                        2: bound = THRESH_W'($urandom_range(16'h800));
                        default: bound = THRESH_W'($urandom_range(16'h7FFF));
                    endcase
                    degrees = DEGREES_W'($urandom_range(63));
                end
            endcase

            // Upper data bits are random so that the register width is exercised.
            setting = {$urandom(), $urandom()};
            setting[THRESH_W-1:0] = bound;
            write_register(ppa_pkg::CFG_THRESHOLD, setting);
            setting = {$urandom(), $urandom()};
            setting[DEGREES_W-1:0] = degrees;
            write_register(ppa_pkg::CFG_DEGREES, setting);
            if (p == 1)
            begin
                write_register(ppa_pkg::CFG_LOWER_COEFFS, '1);
                write_register(ppa_pkg::CFG_MIDDLE_COEFFS, '0);
                write_register(ppa_pkg::CFG_UPPER_COEFFS, {NUM_COEFFS{16'h8000}});
            end
            else
            begin
                write_register(ppa_pkg::CFG_LOWER_COEFFS, random_coeffs());
                write_register(ppa_pkg::CFG_MIDDLE_COEFFS, random_coeffs());
                write_register(ppa_pkg::CFG_UPPER_COEFFS, random_coeffs());
            end

            no_idle = (p == QUIET_PHASE);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                for (int lane = 0; lane < LANES_N; lane++)
                    samples[lane*LANE_W +: LANE_W] = random_sample();
                count = ($urandom_range(99) < 60) ? COUNT_W'(LANES_N)
                                                  : COUNT_W'($urandom_range(7));
                push_beat(samples, count, 1'b0, '0);
            end
            no_idle = 1'b0;
        end

        // Drain everything owed, then give the pipeline time to show any
        // stray beat before the verdict.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("piecewise_poly_activation_lanes_core verification clean");
        else
            $display("piecewise_poly_activation_lanes_core verification failed");
        $finish;
    end

endmodule
